### rtl/bicubic_pixel_interpolator_macros.svh
// Assertion macros shared by the checkers of the bicubic pixel interpolator.
// Include this header by its bare file name; it depends on nothing else.
`ifndef BICUBIC_PIXEL_INTERPOLATOR_MACROS_SVH
`define BICUBIC_PIXEL_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define BPI_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bicubic checker: same-cycle property failed");

// Next-cycle implication, switched off while reset is high.
`define BPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bicubic checker: next-cycle property failed");

// Next-cycle implication that stays active during reset.
`define BPI_ASSERT_RESET(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bicubic checker: reset property failed");

`endif

### rtl/bpi_pkg.sv
// Shared types and constants of the bicubic pixel interpolator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package bpi_pkg;

  localparam int TAPS       = 4;
  localparam int PIX_W      = 8;
  localparam int ROW_W      = TAPS * PIX_W;
  localparam int FRAC_IN_W  = 8;
  localparam int FRAC_BITS_DEFAULT = 8;

  // Kernel coefficient a, Q.8.
  localparam int COEFF_W    = 9;
  localparam int COEFF_FRAC = 8;
  localparam int COEFF_RESET = -128;
  localparam int COEFF_ONE  = 1 << COEFF_FRAC;
  localparam int A2_OFS     = 2 * COEFF_ONE;  // 2 in Q.8, the offset of a + 2
  localparam int A3_OFS     = 3 * COEFF_ONE;  // 3 in Q.8, the offset of a + 3

  // Weights are signed Q2.14; the final sum carries two weights' fractions.
  localparam int WGT_W      = 16;
  localparam int WGT_FRAC   = 14;
  localparam int SUM_FRAC   = 2 * WGT_FRAC;

  // Lane and merge arithmetic widths.
  localparam int PROD_W     = PIX_W + 1 + WGT_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int LANE_W     = ACC_W + WGT_W;
  localparam int SUM_W      = LANE_W + 2;

  // Pipeline depth of each section.
  localparam int W_STAGES   = 4;
  localparam int L_STAGES   = 3;
  localparam int M_STAGES   = 2;
  localparam int N_STAGES   = W_STAGES + L_STAGES + M_STAGES;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_COEFF = 1'b0;

  typedef logic signed [WGT_W-1:0]   wgt_t;
  typedef logic signed [COEFF_W-1:0] coeff_t;
  typedef logic signed [LANE_W-1:0]  lane_t;
  typedef logic [TAPS-1:0][ROW_W-1:0] row_set_t;

  // Per-stage load enables, one bit per pipeline register stage.
  typedef struct packed {
    logic [W_STAGES-1:0] wgt;
    logic [L_STAGES-1:0] lane;
    logic [M_STAGES-1:0] mrg;
  } bpi_adv_t;

endpackage

### rtl/bpi_weight_unit.sv
// Four-stage Keys cubic weight generator for one fractional position.
// Depends on bpi_pkg.
`timescale 1ns / 1ps

module bpi_weight_unit #(
  parameter int FRAC_BITS = bpi_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  bpi_pkg::bpi_adv_t            adv,
  input  logic [bpi_pkg::FRAC_IN_W-1:0] frac,
  input  bpi_pkg::coeff_t              coeff,
  output bpi_pkg::wgt_t                wgt [bpi_pkg::TAPS]
);
  import bpi_pkg::*;

  localparam int TW  = FRAC_BITS + 1;
  localparam int SQW = 2 * TW;
  localparam int MW  = FRAC_BITS + 12;
  localparam int PW  = FRAC_BITS + 10;
  localparam int NW  = 3 * FRAC_BITS + 12;
  localparam int K   = 3 * FRAC_BITS + COEFF_FRAC - WGT_FRAC;

  localparam logic [TW-1:0] T_MASK = TW'((1 << FRAC_BITS) - 1);
  localparam logic [TW-1:0] S_ONE  = TW'(1) << FRAC_BITS;
  localparam logic signed [NW-1:0] BIAS = NW'(1) << (3 * FRAC_BITS + COEFF_FRAC);
  localparam logic signed [NW-1:0] HALF = NW'(1) << (K - 1);

  // Stage 1: t, u = S - t and their products.
  logic [TW-1:0]  t_c, u_c, t_r, u_r;
  logic [SQW-1:0] t2_r, u2_r, tu_r, t2_d, u2_d, tu_d;

  assign t_c = TW'(frac) & T_MASK;
  assign u_c = S_ONE - t_c;

  always_ff @(posedge clk) begin
    if (adv.wgt[0]) begin
      t_r  <= t_c;
      u_r  <= u_c;
      t2_r <= SQW'(t_c) * SQW'(t_c);
      u2_r <= SQW'(u_c) * SQW'(u_c);
      tu_r <= SQW'(t_c) * SQW'(u_c);
    end
  end

  // Stage 2: linear factors of the cubic terms.
  logic signed [MW-1:0] cp2, cp3, m1_r, m2_r;
  logic signed [PW-1:0] p0_r, p3_r;

  assign cp2 = MW'(coeff) + MW'(A2_OFS);
  assign cp3 = MW'(coeff) + MW'(A3_OFS);

  always_ff @(posedge clk) begin
    if (adv.wgt[1]) begin
      m1_r <= $signed(MW'(t_r)) * cp2 - (cp3 <<< FRAC_BITS);
      m2_r <= $signed(MW'(u_r)) * cp2 - (cp3 <<< FRAC_BITS);
      p0_r <= $signed(PW'(u_r)) * PW'(coeff);
      p3_r <= $signed(PW'(t_r)) * PW'(coeff);
      t2_d <= t2_r;
      u2_d <= u2_r;
      tu_d <= tu_r;
    end
  end

  // Stage 3: exact numerators over 256 * S^3.
  logic signed [NW-1:0] n_r [TAPS];

  always_ff @(posedge clk) begin
    if (adv.wgt[2]) begin
      n_r[0] <= NW'(p0_r) * $signed(NW'(tu_d));
      n_r[1] <= $signed(NW'(t2_d)) * NW'(m1_r) + BIAS;
      n_r[2] <= $signed(NW'(u2_d)) * NW'(m2_r) + BIAS;
      n_r[3] <= NW'(p3_r) * $signed(NW'(tu_d));
    end
  end

  // Stage 4: round to Q2.14, half away from zero. For a negative numerator
  // adding half minus one before the arithmetic shift gives the same result.
  logic signed [NW-1:0] rnd [TAPS];

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      rnd[i] = n_r[i] + HALF - $signed(NW'(n_r[i][NW-1]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv.wgt[3]) begin
      for (int i = 0; i < TAPS; i++) begin
        wgt[i] <= WGT_W'(rnd[i] >>> K);
      end
    end
  end

endmodule

### rtl/bpi_lane.sv
// One window row lane: weighs four samples by the column weights, then by the
// row weight, over three pipeline stages. Depends on bpi_pkg.
`timescale 1ns / 1ps

module bpi_lane (
  input  logic                     clk,
  input  bpi_pkg::bpi_adv_t        adv,
  input  logic [bpi_pkg::ROW_W-1:0] row,
  input  bpi_pkg::wgt_t            wcol [bpi_pkg::TAPS],
  input  bpi_pkg::wgt_t            wrow,
  output bpi_pkg::lane_t           lane_sum
);
  import bpi_pkg::*;

  logic signed [PROD_W-1:0] prod [TAPS];
  logic signed [ACC_W-1:0]  acc;
  wgt_t                     wrow_d1, wrow_d2;

  always_ff @(posedge clk) begin
    if (adv.lane[0]) begin
      for (int i = 0; i < TAPS; i++) begin
        prod[i] <= $signed(PROD_W'(row[i*PIX_W +: PIX_W])) * PROD_W'(wcol[i]);
      end
      wrow_d1 <= wrow;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.lane[1]) begin
      acc <= ACC_W'(prod[0]) + ACC_W'(prod[1]) + ACC_W'(prod[2]) + ACC_W'(prod[3]);
      wrow_d2 <= wrow_d1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.lane[2]) begin
      lane_sum <= LANE_W'(acc) * LANE_W'(wrow_d2);
    end
  end

endmodule

### rtl/bpi_merge.sv
// Merges the four lane sums, then rounds and clamps into the output register.
// Depends on bpi_pkg.
`timescale 1ns / 1ps

module bpi_merge (
  input  logic                     clk,
  input  bpi_pkg::bpi_adv_t        adv,
  input  bpi_pkg::lane_t           lane_sum [bpi_pkg::TAPS],
  output logic [bpi_pkg::PIX_W-1:0] pixel_out
);
  import bpi_pkg::*;

  localparam int VW = SUM_W - SUM_FRAC;
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (SUM_FRAC - 1);
  localparam logic [VW-1:0] PIX_MAX = VW'((1 << PIX_W) - 1);

  logic signed [SUM_W-1:0] total, rounded;
  logic [VW-1:0]           whole;
  logic [PIX_W-1:0]        pix_c;

  always_ff @(posedge clk) begin
    if (adv.mrg[0]) begin
      total <= SUM_W'(lane_sum[0]) + SUM_W'(lane_sum[1]) +
               SUM_W'(lane_sum[2]) + SUM_W'(lane_sum[3]);
    end
  end

  // Ties round upward; a negative total gives black, an overflow gives white.
  assign rounded = total + RND_HALF;
  assign whole   = rounded[SUM_W-1:SUM_FRAC];

  always_comb begin
    if (total[SUM_W-1]) begin
      pix_c = '0;
    end else if (whole > PIX_MAX) begin
      pix_c = PIX_MAX[PIX_W-1:0];
    end else begin
      pix_c = whole[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.mrg[1]) begin
      pixel_out <= pix_c;
    end
  end

endmodule

### rtl/bicubic_pixel_interpolator.sv
// Bicubic pixel interpolator: an accepted request passes 4 weight stages, 3 lane stages,
// the merge stage and the output register, whose valid bit drives pixel_valid.
// Throughput one request per cycle while item_stall is low; every stage has its own
// valid bit, so bubbles close up and a request is taken while a finished pixel waits on
// pixel_stall unless every stage is full.
// Reset clears all valid bits and sets kernel_coeff to -128 (a = -0.5).
`timescale 1ns / 1ps

module bicubic_pixel_interpolator #(
  parameter int FRAC_BITS = bpi_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Request channel.
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [bpi_pkg::ROW_W-1:0]         row_above,
  input  logic [bpi_pkg::ROW_W-1:0]         row_center,
  input  logic [bpi_pkg::ROW_W-1:0]         row_below,
  input  logic [bpi_pkg::ROW_W-1:0]         row_below_two,
  input  logic [bpi_pkg::FRAC_IN_W-1:0]     frac_row,
  input  logic [bpi_pkg::FRAC_IN_W-1:0]     frac_col,
  // Result channel.
  output logic                              pixel_valid,
  input  logic                              pixel_stall,
  output logic [bpi_pkg::PIX_W-1:0]         pixel_out,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpi_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bpi_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bpi_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import bpi_pkg::*;

  // Configuration register.
  coeff_t                kernel_coeff;
  logic [REG_IDX_W-1:0]  reg_idx;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_coeff <= COEFF_W'(COEFF_RESET);
    end else if (psel && penable && pwrite && pready && reg_idx == REG_KERNEL_COEFF) begin
      kernel_coeff <= $signed(pwdata[COEFF_W-1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_KERNEL_COEFF) begin
      prdata = APB_DATA_W'(kernel_coeff);
    end
  end

  // Stage valid bits and the load enables derived from them.
  logic [N_STAGES-1:0] vld;
  logic [N_STAGES-1:0] rdy;
  bpi_adv_t            adv;

  always_comb begin
    rdy[N_STAGES-1] = !vld[N_STAGES-1] || !pixel_stall;
    for (int i = N_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign adv.wgt  = rdy[W_STAGES-1:0];
  assign adv.lane = rdy[W_STAGES+L_STAGES-1:W_STAGES];
  assign adv.mrg  = rdy[N_STAGES-1:W_STAGES+L_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= item_valid;
      end
      for (int i = 1; i < N_STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign item_stall  = !rdy[0];
  assign pixel_valid = vld[N_STAGES-1];

  // Window rows travel alongside the weight pipeline.
  row_set_t rows_in;
  row_set_t rows_dly [W_STAGES];

  assign rows_in = {row_below_two, row_below, row_center, row_above};

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rows_dly[0] <= rows_in;
    end
    for (int i = 1; i < W_STAGES; i++) begin
      if (rdy[i]) begin
        rows_dly[i] <= rows_dly[i-1];
      end
    end
  end

  // Weight generators for the row and the column position.
  wgt_t wgt_row [TAPS];
  wgt_t wgt_col [TAPS];

  bpi_weight_unit #(.FRAC_BITS(FRAC_BITS)) u_wgt_row (
    .clk   (clk),
    .adv   (adv),
    .frac  (frac_row),
    .coeff (kernel_coeff),
    .wgt   (wgt_row)
  );

  bpi_weight_unit #(.FRAC_BITS(FRAC_BITS)) u_wgt_col (
    .clk   (clk),
    .adv   (adv),
    .frac  (frac_col),
    .coeff (kernel_coeff),
    .wgt   (wgt_col)
  );

  // One lane per window row.
  lane_t lane_sum [TAPS];

  for (genvar r = 0; r < TAPS; r++) begin : g_lane
    bpi_lane u_lane (
      .clk      (clk),
      .adv      (adv),
      .row      (rows_dly[W_STAGES-1][r]),
      .wcol     (wgt_col),
      .wrow     (wgt_row[r]),
      .lane_sum (lane_sum[r])
    );
  end

  bpi_merge u_merge (
    .clk       (clk),
    .adv       (adv),
    .lane_sum  (lane_sum),
    .pixel_out (pixel_out)
  );

endmodule

### rtl/bicubic_pixel_interpolator_checker.sv
// Port-level checker for the bicubic pixel interpolator, bound to the top level.
// Depends on bpi_pkg and bicubic_pixel_interpolator_macros.svh.
`timescale 1ns / 1ps
`include "bicubic_pixel_interpolator_macros.svh"

module bicubic_pixel_interpolator_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              item_stall,
  input logic                              pixel_valid,
  input logic                              pixel_stall,
  input logic [bpi_pkg::PIX_W-1:0]         pixel_out,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [bpi_pkg::APB_ADDR_W-1:0]    paddr,
  input logic [bpi_pkg::APB_DATA_W-1:0]    pwdata,
  input logic [bpi_pkg::APB_DATA_W-1:0]    prdata,
  input logic                              pready
);
  import bpi_pkg::*;

  logic               out_held;
  logic               coeff_sel;
  logic               coeff_wr;
  logic [COEFF_W-1:0] coeff_rd;
  logic [COEFF_W-1:0] coeff_wd;

  assign out_held  = pixel_valid && pixel_stall;
  assign coeff_sel = paddr[APB_ADDR_W-1:2] == REG_KERNEL_COEFF;
  assign coeff_wr  = psel && penable && pwrite && pready && coeff_sel;
  assign coeff_rd  = prdata[COEFF_W-1:0];
  assign coeff_wd  = pwdata[COEFF_W-1:0];

  // The pipeline is empty right after reset.
  `BPI_ASSERT_RESET(a_reset_empty, clk, rst, !pixel_valid && !item_stall)

  // Requests are only held off while a valid output pixel is stalled.
  `BPI_ASSERT_SAME(a_stall_only_when_full, clk, rst, item_stall, out_held)

  // A stalled pixel stays put.
  `BPI_ASSERT_NEXT(a_pixel_hold, clk, rst, out_held, pixel_valid && $stable(pixel_out))

  // A coefficient write is read back in the following cycle at the same register.
  `BPI_ASSERT_NEXT(a_coeff_readback, clk, rst, coeff_wr, !coeff_sel || coeff_rd == $past(coeff_wd))

endmodule

bind bicubic_pixel_interpolator bicubic_pixel_interpolator_checker u_checker (.*);

### sim/tb.sv
// Self-checking testbench for bicubic_pixel_interpolator: window requests in, pixels out.
// Has its own Keys-kernel pixel predictor and checks results in order.
// Depends on rtl/bpi_pkg.sv and rtl/bicubic_pixel_interpolator.sv.
`timescale 1ns / 1ps

module tb;
  import bpi_pkg::*;

  localparam int FRAC_BITS   = FRAC_BITS_DEFAULT;
  localparam int WGT_SHIFT   = 3 * FRAC_BITS + COEFF_FRAC - WGT_FRAC;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIRECTED  = 16;
  localparam int PHASE_ITEMS = 250;

  typedef struct packed {
    logic [ROW_W-1:0]     above;
    logic [ROW_W-1:0]     center;
    logic [ROW_W-1:0]     below;
    logic [ROW_W-1:0]     below_two;
    logic [FRAC_IN_W-1:0] frac_row;
    logic [FRAC_IN_W-1:0] frac_col;
  } window_req_t;

  typedef struct packed {
    window_req_t      req;
    logic             known;
    logic [PIX_W-1:0] pixel;
  } directed_row_t;

  // Rows: above, center, below, below_two, frac_row, frac_col; then whether the pixel is
  // typed in, and the pixel. Coefficient is the reset value a = -0.5.
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{'{32'h0, 32'h0, 32'h0, 32'h0, 8'd0, 8'd0}, 1'b1, 8'd0},
    '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd0, 8'd0}, 1'b1, 8'd255},
    // Zero fraction picks the center sample and nothing else.
    '{'{32'hFFFFFFFF, 32'h00005A00, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd0, 8'd0}, 1'b1, 8'd90},
    // Ringing of the kernel drives the sum negative, then above full scale.
    '{'{32'h0, 32'hFF0000FF, 32'h0, 32'h0, 8'd0, 8'd128}, 1'b1, 8'd0},
    '{'{32'h0, 32'h00FFFF00, 32'h0, 32'h0, 8'd0, 8'd128}, 1'b1, 8'd255},
    '{'{32'h0000FF00, 32'h0, 32'h0, 32'h0000FF00, 8'd128, 8'd0}, 1'b1, 8'd0},
    '{'{32'h0, 32'h0000FF00, 32'h0000FF00, 32'h0, 8'd128, 8'd0}, 1'b1, 8'd255},
    // Exactly one half: the tie rounds up.
    '{'{32'h0, 32'h00000101, 32'h0, 32'h0, 8'd0, 8'd128}, 1'b1, 8'd1},
    '{'{32'h12345678, 32'h9ABCDEF0, 32'h0F1E2D3C, 32'h4B5A6978, 8'd255, 8'd255}, 1'b0, 8'd0},
    '{'{32'h80808080, 32'h7F7F7F7F, 32'h80808080, 32'h7F7F7F7F, 8'd1, 8'd1}, 1'b0, 8'd0},
    '{'{32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 8'd255, 8'd0}, 1'b0, 8'd0},
    '{'{32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 8'd0, 8'd255}, 1'b0, 8'd0},
    '{'{32'h40506070, 32'h50607080, 32'h60708090, 32'h708090A0, 8'd128, 8'd128}, 1'b0, 8'd0},
    '{'{32'hFF00FF00, 32'h00FF00FF, 32'hFF00FF00, 32'h00FF00FF, 8'd64, 8'd192}, 1'b0, 8'd0},
    '{'{32'h01020304, 32'hFEFDFCFB, 32'h10203040, 32'hEFDFCFBF, 8'd127, 8'd129}, 1'b0, 8'd0},
    '{'{32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0, 8'd200, 8'd55}, 1'b0, 8'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid;
  logic                  item_stall;
  logic [ROW_W-1:0]      row_above;
  logic [ROW_W-1:0]      row_center;
  logic [ROW_W-1:0]      row_below;
  logic [ROW_W-1:0]      row_below_two;
  logic [FRAC_IN_W-1:0]  frac_row;
  logic [FRAC_IN_W-1:0]  frac_col;
  logic                  pixel_valid;
  logic                  pixel_stall = 1'b0;
  logic [PIX_W-1:0]      pixel_out;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [PIX_W-1:0] expected_pixels [$];
  logic [PIX_W-1:0] oldest_pixel;
  coeff_t           coeff_shadow;
  int               sender_idle_pct = 0;
  int               receiver_stall_pct = 0;
  int               error_count = 0;
  int               cycle_count = 0;
  int               hold_left = 0;
  logic             hold_arm = 1'b0;
  logic             hold_taken = 1'b0;

  bicubic_pixel_interpolator i_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .row_above     (row_above),
    .row_center    (row_center),
    .row_below     (row_below),
    .row_below_two (row_below_two),
    .frac_row      (frac_row),
    .frac_col      (frac_col),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .pixel_out     (pixel_out),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk = ~clk;

  // Rounds num / 2^k to nearest, halves away from zero.
  function automatic longint round_half_away(input longint num, input int k);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + (longint'(1) <<< (k - 1))) >>> k;
    return (num < 0) ? -mag : mag;
  endfunction

  // Q2.14 weight of one tap of the Keys kernel; taps sit at distances 1+t, t, 1-t, 2-t.
  function automatic longint keys_tap(input int tap, input logic [FRAC_IN_W-1:0] frac,
                                      input coeff_t a);
    longint s, t, u, c, n;
    s = longint'(1) <<< FRAC_BITS;
    t = longint'(frac) & (s - 1);
    u = s - t;
    c = longint'(a);
    case (tap)
      0: n = c * t * u * u;
      1: n = (c + A2_OFS) * t * t * t - (c + A3_OFS) * t * t * s + COEFF_ONE * s * s * s;
      2: n = (c + A2_OFS) * u * u * u - (c + A3_OFS) * u * u * s + COEFF_ONE * s * s * s;
      default: n = c * u * t * t;
    endcase
    return round_half_away(n, WGT_SHIFT);
  endfunction

  function automatic logic [PIX_W-1:0] interpolate_pixel(input window_req_t r,
                                                         input coeff_t a);
    row_set_t rows;
    longint   sum, acc, px, v;
    int       ri, ci;
    rows = {r.below_two, r.below, r.center, r.above};
    sum = 0;
    for (ri = 0; ri < TAPS; ri++) begin
      acc = 0;
      for (ci = 0; ci < TAPS; ci++) begin
        px = longint'(rows[ri][PIX_W*ci +: PIX_W]);
        acc += px * keys_tap(ci, r.frac_col, a);
      end
      sum += acc * keys_tap(ri, r.frac_row, a);
    end
    if (sum < 0) return '0;
    v = (sum + (longint'(1) <<< (SUM_FRAC - 1))) >>> SUM_FRAC;
    return (v > 255) ? 8'd255 : v[PIX_W-1:0];
  endfunction

  function automatic logic [FRAC_IN_W-1:0] random_frac();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      default: return FRAC_IN_W'($urandom_range(255, 0));
    endcase
  endfunction

  // Mixes plain noise, hard black-and-white edges that provoke clamping, and smooth patches.
  function automatic window_req_t random_window();
    window_req_t r;
    row_set_t    rows;
    int          style, ri, bi, base;
    style = $urandom_range(3, 0);
    base = $urandom_range(255, 0);
    for (ri = 0; ri < TAPS; ri++) begin
      for (bi = 0; bi < TAPS; bi++) begin
        case (style)
          2: rows[ri][PIX_W*bi +: PIX_W] = $urandom_range(1, 0) ? 8'hFF : 8'h00;
          3: rows[ri][PIX_W*bi +: PIX_W] = PIX_W'(base + $urandom_range(16, 0));
          default: rows[ri][PIX_W*bi +: PIX_W] = PIX_W'($urandom);
        endcase
      end
    end
    r.above     = rows[0];
    r.center    = rows[1];
    r.below     = rows[2];
    r.below_two = rows[3];
    r.frac_row  = random_frac();
    r.frac_col  = random_frac();
    return r;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the request.
  task automatic send_window(input window_req_t r, input logic [PIX_W-1:0] pixel);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid    <= 1'b1;
    row_above     <= r.above;
    row_center    <= r.center;
    row_below     <= r.below;
    row_below_two <= r.below_two;
    frac_row      <= r.frac_row;
    frac_col      <= r.frac_col;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected_pixels.push_back(pixel);
  endtask

  task automatic drain_pixels();
    item_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (N_STAGES + 4) @(posedge clk);
  endtask

  // Write, then read back; the register is written at the edge that ends the access cycle.
  task automatic write_kernel_coeff(input coeff_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_KERNEL_COEFF, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    coeff_shadow = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[COEFF_W-1:0] !== value) begin
      $display("%0t: kernel_coeff readback expected %0d, actual %0d", $time, value,
               $signed(prdata[COEFF_W-1:0]));
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input coeff_t value, input int idle_pct, input int stall_pct,
                           input int count);
    window_req_t r;
    int          n;
    write_kernel_coeff(value);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (n = 0; n < count; n++) begin
      r = random_window();
      send_window(r, interpolate_pixel(r, coeff_shadow));
    end
    drain_pixels();
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      pixel_stall <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_arm && !hold_taken) begin
      pixel_stall <= 1'b1;
      hold_left   <= LONG_HOLD;
      hold_taken  <= 1'b1;
    end else begin
      pixel_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pixel_valid && !pixel_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: pixel with nothing expected, expected none, actual %0d", $time,
                 pixel_out);
        error_count++;
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        if (pixel_out !== oldest_pixel) begin
          $display("%0t: pixel_out expected %0d, actual %0d", $time, oldest_pixel,
                   pixel_out);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    window_req_t r;
    int          i;
    item_valid    = 1'b0;
    row_above     = '0;
    row_center    = '0;
    row_below     = '0;
    row_below_two = '0;
    frac_row      = '0;
    frac_col      = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    coeff_shadow  = coeff_t'(COEFF_RESET);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < N_DIRECTED; i++) begin
      r = DIRECTED[i].req;
      send_window(r, DIRECTED[i].known ? DIRECTED[i].pixel
                                       : interpolate_pixel(r, coeff_shadow));
    end
    drain_pixels();

    run_phase(coeff_t'(COEFF_RESET), 0, 0, PHASE_ITEMS);
    run_phase(-9'sd256, 76, 0, PHASE_ITEMS);
    run_phase(9'sd255, 0, 76, PHASE_ITEMS);
    run_phase(9'sd0, 13, 13, PHASE_ITEMS);
    // The receiver holds off long enough for the pipeline to fill and push back.
    hold_arm <= 1'b1;
    run_phase(coeff_t'($urandom_range(511, 0)), 0, 0, PHASE_ITEMS);
    run_phase(-9'sd1, 76, 0, PHASE_ITEMS);
    run_phase(coeff_t'($urandom_range(511, 0)), 0, 76, PHASE_ITEMS);
    run_phase(-9'sd64, 13, 13, PHASE_ITEMS);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/bpi_pkg.sv
rtl/bpi_weight_unit.sv
rtl/bpi_lane.sv
rtl/bpi_merge.sv
rtl/bicubic_pixel_interpolator.sv
rtl/bicubic_pixel_interpolator_checker.sv
sim/tb.sv
